>>> hdl/tqs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqs_pkg: shared types and codes of the two-queue priority scheduler
// Beat formats of both channels, the queue entry, the control states and the
// status codes.
// ----------------------------------------------------------------------------
package tqs_pkg;

  // Default number of entries in each queue ring
  localparam int QueueDepthDef = 16;

  // Width of queue sizes and of the capacity register
  localparam int CNT_W = 5;

  // Opcode codes; the upper opcode bit marks a service tick
  localparam logic [1:0] OP_REQ_HIGH = 2'd0;
  localparam logic [1:0] OP_REQ_LOW  = 2'd1;
  localparam int         OP_TICK_BIT = 1;

  typedef enum logic [2:0] {
    ST_ACCEPTED    = 3'd0,
    ST_REFUSED     = 3'd1,
    ST_IDLE_TICK   = 3'd2,
    ST_SERVED_HIGH = 3'd3,
    ST_SERVED_LOW  = 3'd4
  } status_e;

  // Scheduler control: take a beat, or wait for the head entry read
  typedef enum logic {
    FSM_IDLE,
    FSM_READ
  } fsm_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] request_id;
    logic [15:0] time_now;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] served_id;
    logic [15:0] wait_time;
    logic [4:0]  high_count;
    logic [4:0]  low_count;
    logic [31:0] high_wait_total;
    logic [31:0] low_wait_total;
    logic [31:0] idle_total;
    logic [31:0] high_refused_total;
    logic [31:0] low_refused_total;
  } out_t;

  // One stored queue entry
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] arrival;
  } entry_t;

endpackage

>>> hdl/tqs_entry_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqs_entry_ram: entry storage of both queues
// One write port and one read port with registered read data. The upper
// address bit selects the queue, the lower bits the ring slot.
// ----------------------------------------------------------------------------
module tqs_entry_ram #(
  parameter int ADDR_W = 5
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  tqs_pkg::entry_t wr_data_i,
  input  logic            rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output tqs_pkg::entry_t rd_data_o
);
  import tqs_pkg::*;

  entry_t mem_q [2**ADDR_W];
  entry_t rd_data_q;

  // Write the entry of an accepted request
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read the head entry; hold the data until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hdl/two_queue_priority_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_queue_priority_scheduler: strict-priority scheduler over two rings
// Keeps a high and a low request ring in one entry RAM, serves the high ring
// first on each service tick and keeps saturating wait, idle and refusal
// totals.
// ----------------------------------------------------------------------------
// The block takes one beat at a time. A request or an idle tick puts its
// result into the output register in the cycle after it is taken; a tick
// that serves an entry reads the head entry into the RAM read register and
// loads its result from there. A new beat is taken once the previous result
// has been loaded and the output register is free or being drained. The
// entry RAM holds 2 x 2**IDX_W entries of id and arrival time; it is not
// cleared after reset, and only written slots are ever read in normal use.
// The capacity register may be written at any time the block is idle.
module two_queue_priority_scheduler #(
  parameter int QUEUE_DEPTH = tqs_pkg::QueueDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  tqs_pkg::in_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output tqs_pkg::out_t out_data_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [tqs_pkg::CNT_W-1:0] cfg_data_i
);
  import tqs_pkg::*;

  localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int ADDR_W = IDX_W + 1;
  localparam int NXT_W  = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

  fsm_e              state_q, state_d;
  logic [CNT_W-1:0]  cap_q;
  logic [CNT_W-1:0]  eff_cap;
  logic [IDX_W-1:0]  high_head_q, high_head_d, high_tail_q, high_tail_d;
  logic [IDX_W-1:0]  low_head_q, low_head_d, low_tail_q, low_tail_d;
  logic [CNT_W-1:0]  high_size_q, high_size_d, low_size_q, low_size_d;
  logic [31:0]       high_wait_q, high_wait_d, low_wait_q, low_wait_d;
  logic [31:0]       idle_q, idle_d, high_ref_q, high_ref_d, low_ref_q, low_ref_d;
  logic              pend_high_q, pend_high_d;
  logic [15:0]       pend_time_q, pend_time_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  logic              can_load;
  logic              load_out;
  status_e           res_status;
  logic [15:0]       res_id;
  logic [15:0]       res_wait;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  entry_t            wr_data, rd_data;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Step a ring index, wrapping at the effective capacity
  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] cap);
    logic [NXT_W-1:0] n;
    n = NXT_W'(idx) + NXT_W'(1);
    return (n >= NXT_W'(cap)) ? '0 : n[IDX_W-1:0];
  endfunction

  // Clamp the capacity register to one .. QUEUE_DEPTH
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (int'(cap_q) > QUEUE_DEPTH) begin
      eff_cap = CNT_W'(QUEUE_DEPTH);
    end else begin
      eff_cap = cap_q;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign can_load    = !out_valid_q || !out_stall_i;

  // Next state, ring pointers, totals and result
  always_comb begin
    state_d     = state_q;
    high_head_d = high_head_q;
    high_tail_d = high_tail_q;
    high_size_d = high_size_q;
    low_head_d  = low_head_q;
    low_tail_d  = low_tail_q;
    low_size_d  = low_size_q;
    high_wait_d = high_wait_q;
    low_wait_d  = low_wait_q;
    idle_d      = idle_q;
    high_ref_d  = high_ref_q;
    low_ref_d   = low_ref_q;
    pend_high_d = pend_high_q;
    pend_time_d = pend_time_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    load_out    = 1'b0;
    res_status  = ST_ACCEPTED;
    res_id      = '0;
    res_wait    = '0;
    wr_en       = 1'b0;
    wr_addr     = {1'b0, high_tail_q};
    wr_data     = '{id: in_data_i.request_id, arrival: in_data_i.time_now};
    rd_en       = 1'b0;
    rd_addr     = {1'b0, high_head_q};
    in_stall_o  = 1'b1;

    case (state_q)
      FSM_IDLE: begin
        in_stall_o = !can_load;
        if (in_valid_i && can_load) begin
          if (in_data_i.opcode[OP_TICK_BIT]) begin
            // Tick: fetch the head of the first non-empty ring
            if (high_size_q != '0) begin
              rd_en       = 1'b1;
              rd_addr     = {1'b0, high_head_q};
              high_head_d = advance(high_head_q, eff_cap);
              high_size_d = high_size_q - CNT_W'(1);
              pend_high_d = 1'b1;
              pend_time_d = in_data_i.time_now;
              state_d     = FSM_READ;
            end else if (low_size_q != '0) begin
              rd_en       = 1'b1;
              rd_addr     = {1'b1, low_head_q};
              low_head_d  = advance(low_head_q, eff_cap);
              low_size_d  = low_size_q - CNT_W'(1);
              pend_high_d = 1'b0;
              pend_time_d = in_data_i.time_now;
              state_d     = FSM_READ;
            end else begin
              idle_d     = sat_add(idle_q, 16'd1);
              res_status = ST_IDLE_TICK;
              load_out   = 1'b1;
            end
          end else if (in_data_i.opcode == OP_REQ_HIGH) begin
            // High request: append or refuse
            load_out = 1'b1;
            if (high_size_q >= eff_cap) begin
              high_ref_d = sat_add(high_ref_q, 16'd1);
              res_status = ST_REFUSED;
            end else begin
              wr_en       = 1'b1;
              wr_addr     = {1'b0, high_tail_q};
              high_tail_d = advance(high_tail_q, eff_cap);
              high_size_d = high_size_q + CNT_W'(1);
            end
          end else begin
            // Low request: append or refuse
            load_out = 1'b1;
            if (low_size_q >= eff_cap) begin
              low_ref_d  = sat_add(low_ref_q, 16'd1);
              res_status = ST_REFUSED;
            end else begin
              wr_en      = 1'b1;
              wr_addr    = {1'b1, low_tail_q};
              low_tail_d = advance(low_tail_q, eff_cap);
              low_size_d = low_size_q + CNT_W'(1);
            end
          end
        end
      end
      FSM_READ: begin
        // Head entry is in the read register; hold it until the result fits
        if (can_load) begin
          res_id   = rd_data.id;
          res_wait = pend_time_q - rd_data.arrival;
          load_out = 1'b1;
          state_d  = FSM_IDLE;
          if (pend_high_q) begin
            high_wait_d = sat_add(high_wait_q, res_wait);
            res_status  = ST_SERVED_HIGH;
          end else begin
            low_wait_d = sat_add(low_wait_q, res_wait);
            res_status = ST_SERVED_LOW;
          end
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase

    // Load the result beat with the state after this step
    if (load_out) begin
      out_valid_d = 1'b1;
      out_d = '{status:             res_status,
                served_id:          res_id,
                wait_time:          res_wait,
                high_count:         high_size_d,
                low_count:          low_size_d,
                high_wait_total:    high_wait_d,
                low_wait_total:     low_wait_d,
                idle_total:         idle_d,
                high_refused_total: high_ref_d,
                low_refused_total:  low_ref_d};
    end
  end

  // Control and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      high_head_q <= '0;
      high_tail_q <= '0;
      high_size_q <= '0;
      low_head_q  <= '0;
      low_tail_q  <= '0;
      low_size_q  <= '0;
      high_wait_q <= '0;
      low_wait_q  <= '0;
      idle_q      <= '0;
      high_ref_q  <= '0;
      low_ref_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      high_head_q <= high_head_d;
      high_tail_q <= high_tail_d;
      high_size_q <= high_size_d;
      low_head_q  <= low_head_d;
      low_tail_q  <= low_tail_d;
      low_size_q  <= low_size_d;
      high_wait_q <= high_wait_d;
      low_wait_q  <= low_wait_d;
      idle_q      <= idle_d;
      high_ref_q  <= high_ref_d;
      low_ref_q   <= low_ref_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CNT_W'(16);
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_high_q <= pend_high_d;
    pend_time_q <= pend_time_d;
    out_q       <= out_d;
  end

  // A write lands at the clock edge of its beat, so a later tick always
  // reads it back; the one-beat-at-a-time flow keeps the ports apart.
  tqs_entry_ram #(
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/tqs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqs_checker: port-level checks of the scheduler
// Watches the beats on both channels and flags results that cannot follow.
// ----------------------------------------------------------------------------
module tqs_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input tqs_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input tqs_pkg::out_t out_data_o
);
  import tqs_pkg::*;

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A request beat yields an accept or refuse result in the next cycle
  a_req_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_data_i.opcode[OP_TICK_BIT] |=>
      out_valid_o && (out_data_o.status == ST_ACCEPTED ||
                      out_data_o.status == ST_REFUSED))
    else $error("request beat without request result");

  // Only served results carry an id and a wait
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_SERVED_HIGH &&
      out_data_o.status != ST_SERVED_LOW |->
      out_data_o.served_id == '0 && out_data_o.wait_time == '0)
    else $error("id or wait on a result that served nothing");

  // An idle tick leaves both rings empty
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_IDLE_TICK |->
      out_data_o.high_count == '0 && out_data_o.low_count == '0)
    else $error("idle tick with entries queued");

  // Low entries are served only while the high ring is empty
  a_low_prio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_SERVED_LOW |->
      out_data_o.high_count == '0)
    else $error("low entry served ahead of high entries");

endmodule

bind two_queue_priority_scheduler tqs_checker u_tqs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

>>> tb/two_queue_priority_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_queue_priority_scheduler_tb: self-checking bench of the priority scheduler
// Walks a short table of request and tick beats, fills both rings, then runs
// random segments under several capacities and idling profiles, and finally
// empties both rings. A behavioural copy of the two rings predicts every
// result beat, which is checked field by field.
// ----------------------------------------------------------------------------
module two_queue_priority_scheduler_tb;
  import tqs_pkg::*;

  localparam int QDEPTH = QueueDepthDef;
  localparam int HI = 0;
  localparam int LO = 1;
  localparam logic [1:0] OP_TICK     = 2'd2;
  localparam logic [1:0] OP_TICK_ALT = 2'd3;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int LONG_HOLD     = 80;
  localparam int SETTLE_CYCLES = 4;
  localparam int SEG_COUNT     = 6;
  localparam int SEG_BEATS     = 280;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  in_t              in_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  out_t             out_data_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CNT_W-1:0] cfg_data_i;

  // Idling controls of the sender and of the receiver
  int gap_pct;
  int stall_pct;
  bit long_hold_req;

  int mismatches = 0;
  int cycle_count = 0;

  // Expected result beats, oldest first
  out_t pending_results[$];

  // Behavioural copy of the scheduler state
  logic [15:0] slot_id  [2][QDEPTH];
  logic [15:0] slot_arr [2][QDEPTH];
  int          ring_head [2];
  int          ring_tail [2];
  int          ring_fill [2];
  logic [31:0] wait_total [2];
  logic [31:0] refused_total [2];
  logic [31:0] idle_total;
  logic [CNT_W-1:0] cap_reg;

  // Directed table
  typedef struct {
    bit               is_cfg;
    logic [CNT_W-1:0] cap;
    in_t              beat;
    bit               typed;
    out_t             want;
  } plan_row_t;

  plan_row_t plan[$];

  two_queue_priority_scheduler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Effective capacity: zero acts as one, above the depth acts as the depth
  function automatic int ring_limit();
    int c;
    c = cap_reg;
    if (c < 1) c = 1;
    if (c > QDEPTH) c = QDEPTH;
    return c;
  endfunction

  function automatic int ring_next(input int idx);
    int n;
    n = idx + 1;
    return (n >= ring_limit()) ? 0 : n;
  endfunction

  // Apply one beat to the state copy and return the result it must produce
  function automatic out_t schedule_step(input in_t beat);
    out_t r;
    int   q;
    int   at;
    r = '0;
    if (beat.opcode[OP_TICK_BIT]) begin
      // Strict priority: high ring first, then low, else idle
      if (ring_fill[HI] != 0) q = HI;
      else if (ring_fill[LO] != 0) q = LO;
      else q = -1;
      if (q < 0) begin
        idle_total = sat_add32(idle_total, 32'd1);
        r.status = ST_IDLE_TICK;
      end else begin
        at = ring_head[q] % QDEPTH;
        r.served_id = slot_id[q][at];
        r.wait_time = beat.time_now - slot_arr[q][at];
        ring_head[q] = ring_next(ring_head[q]);
        ring_fill[q] = ring_fill[q] - 1;
        wait_total[q] = sat_add32(wait_total[q], {16'd0, r.wait_time});
        r.status = (q == HI) ? ST_SERVED_HIGH : ST_SERVED_LOW;
      end
    end else begin
      q = (beat.opcode == OP_REQ_HIGH) ? HI : LO;
      if (ring_fill[q] >= ring_limit()) begin
        refused_total[q] = sat_add32(refused_total[q], 32'd1);
        r.status = ST_REFUSED;
      end else begin
        at = ring_tail[q] % QDEPTH;
        slot_id[q][at]  = beat.request_id;
        slot_arr[q][at] = beat.time_now;
        ring_tail[q] = ring_next(ring_tail[q]);
        ring_fill[q] = ring_fill[q] + 1;
        r.status = ST_ACCEPTED;
      end
    end
    r.high_count         = ring_fill[HI][4:0];
    r.low_count          = ring_fill[LO][4:0];
    r.high_wait_total    = wait_total[HI];
    r.low_wait_total     = wait_total[LO];
    r.idle_total         = idle_total;
    r.high_refused_total = refused_total[HI];
    r.low_refused_total  = refused_total[LO];
    return r;
  endfunction

  function automatic in_t make_beat(input logic [1:0] op, input logic [15:0] id,
                                    input logic [15:0] t);
    in_t b;
    b.opcode     = op;
    b.request_id = id;
    b.time_now   = t;
    return b;
  endfunction

  function automatic void plan_item(input logic [1:0] op, input logic [15:0] id,
                                    input logic [15:0] t);
    plan_row_t row;
    row = '{is_cfg: 1'b0, cap: '0, beat: make_beat(op, id, t), typed: 1'b0, want: '0};
    plan.push_back(row);
  endfunction

  function automatic void plan_typed(input logic [1:0] op, input logic [15:0] id,
                                     input logic [15:0] t, input out_t want);
    plan_row_t row;
    row = '{is_cfg: 1'b0, cap: '0, beat: make_beat(op, id, t), typed: 1'b1, want: want};
    plan.push_back(row);
  endfunction

  function automatic void plan_cap(input logic [CNT_W-1:0] value);
    plan_row_t row;
    row = '{is_cfg: 1'b1, cap: value, beat: '0, typed: 1'b0, want: '0};
    plan.push_back(row);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Offer one beat, optionally after a random gap, and record its result
  task automatic send_beat(input in_t beat, input bit typed, input out_t want);
    out_t predicted;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    predicted = schedule_step(beat);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Hold the sender until every result is in, then write the capacity
  task automatic write_capacity(input logic [CNT_W-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cap_reg = value;
  endtask

  // Receiver: random stall, plus one long hold-off on request
  initial begin : receiver
    bit long_hold_done;
    long_hold_done = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", {29'd0, out_data_o.status}, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch("status", {29'd0, out_data_o.status}, {29'd0, want.status});
        if (out_data_o.served_id !== want.served_id)
          report_mismatch("served_id", {16'd0, out_data_o.served_id}, {16'd0, want.served_id});
        if (out_data_o.wait_time !== want.wait_time)
          report_mismatch("wait_time", {16'd0, out_data_o.wait_time}, {16'd0, want.wait_time});
        if (out_data_o.high_count !== want.high_count)
          report_mismatch("high_count", {27'd0, out_data_o.high_count}, {27'd0, want.high_count});
        if (out_data_o.low_count !== want.low_count)
          report_mismatch("low_count", {27'd0, out_data_o.low_count}, {27'd0, want.low_count});
        if (out_data_o.high_wait_total !== want.high_wait_total)
          report_mismatch("high_wait_total", out_data_o.high_wait_total, want.high_wait_total);
        if (out_data_o.low_wait_total !== want.low_wait_total)
          report_mismatch("low_wait_total", out_data_o.low_wait_total, want.low_wait_total);
        if (out_data_o.idle_total !== want.idle_total)
          report_mismatch("idle_total", out_data_o.idle_total, want.idle_total);
        if (out_data_o.high_refused_total !== want.high_refused_total)
          report_mismatch("high_refused_total", out_data_o.high_refused_total,
                          want.high_refused_total);
        if (out_data_o.low_refused_total !== want.low_refused_total)
          report_mismatch("low_refused_total", out_data_o.low_refused_total,
                          want.low_refused_total);
      end
    end
  end

  initial begin : stimulus
    int               tick_pct;
    int               high_pct;
    int               hi_left;
    int               lo_left;
    logic [1:0]       op;
    logic [CNT_W-1:0] seg_cap;

    // Known levels from the start, reset held low at first
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    gap_pct       = 0;
    stall_pct     = 0;
    long_hold_req = 1'b0;
    cap_reg       = 5'd16;
    idle_total    = '0;
    for (int q = 0; q < 2; q++) begin
      ring_head[q]     = 0;
      ring_tail[q]     = 0;
      ring_fill[q]     = 0;
      wait_total[q]    = '0;
      refused_total[q] = '0;
    end

    // Directed table: extremes, every opcode, refusal, capacity corners
    plan_typed(OP_TICK, 16'h0000, 16'h0000,
               out_t'{ST_IDLE_TICK, 16'h0, 16'h0, 5'd0, 5'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0});
    plan_typed(OP_REQ_HIGH, 16'hFFFF, 16'hFFFF,
               out_t'{ST_ACCEPTED, 16'h0, 16'h0, 5'd1, 5'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0});
    plan_typed(OP_REQ_LOW, 16'h0000, 16'h0000,
               out_t'{ST_ACCEPTED, 16'h0, 16'h0, 5'd1, 5'd1, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0});
    plan_item(OP_REQ_HIGH, 16'h1234, 16'h0010);
    // Wait wraps past zero: 0x0000 - 0xFFFF is one
    plan_typed(OP_TICK, 16'hFFFF, 16'h0000,
               out_t'{ST_SERVED_HIGH, 16'hFFFF, 16'h0001, 5'd1, 5'd1,
                      32'd1, 32'd0, 32'd1, 32'd0, 32'd0});
    plan_item(OP_TICK_ALT, 16'h0000, 16'h8000);
    plan_item(OP_TICK, 16'h5A5A, 16'hFFFF);
    plan_item(OP_TICK_ALT, 16'hFFFF, 16'hFFFF);
    // Capacity zero acts as one
    plan_cap(5'd0);
    plan_item(OP_REQ_HIGH, 16'hAAAA, 16'h5555);
    plan_item(OP_REQ_HIGH, 16'h5555, 16'hAAAA);
    plan_item(OP_REQ_LOW, 16'h00FF, 16'h0100);
    plan_item(OP_REQ_LOW, 16'hFF00, 16'h00FF);
    plan_item(OP_TICK, 16'h0000, 16'h7FFF);
    plan_item(OP_TICK, 16'h0000, 16'h8001);
    // Above the depth acts as the depth; then shrink with entries queued
    plan_cap(5'd31);
    plan_item(OP_REQ_HIGH, 16'h0001, 16'h0100);
    plan_item(OP_REQ_HIGH, 16'h0002, 16'h0200);
    plan_item(OP_REQ_HIGH, 16'h0003, 16'h0300);
    plan_cap(5'd2);
    plan_item(OP_REQ_HIGH, 16'h0004, 16'h0400);
    plan_item(OP_TICK, 16'h0000, 16'h1000);
    plan_item(OP_TICK, 16'h0000, 16'h2000);
    plan_item(OP_TICK, 16'h0000, 16'h3000);
    plan_item(OP_TICK, 16'h0000, 16'h4000);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_capacity(plan[i].cap);
      else send_beat(plan[i].beat, plan[i].typed, plan[i].want);
    end

    // Write every slot of both rings once, so later capacity changes never
    // bring a head onto an empty slot
    write_capacity(5'd16);
    hi_left = QDEPTH;
    lo_left = QDEPTH;
    while (hi_left + lo_left != 0) begin
      if (hi_left != 0 && (lo_left == 0 || $urandom_range(1) == 1)) begin
        op = OP_REQ_HIGH;
        hi_left--;
      end else begin
        op = OP_REQ_LOW;
        lo_left--;
      end
      send_beat(make_beat(op, 16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF))),
                1'b0, '0);
    end

    // Random segments: capacity and idling profile change between segments
    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      case (seg)
        0: seg_cap = 5'd3;
        1: seg_cap = 5'd16;
        2: seg_cap = 5'd1;
        3: seg_cap = 5'd8;
        4: seg_cap = 5'd17;
        default: seg_cap = 5'($urandom_range(31));
      endcase
      write_capacity(seg_cap);
      gap_pct   = (seg < 2) ? 24 : (seg < 4) ? 83 : 0;
      stall_pct = (seg < 2) ? 83 : (seg < 4) ? 24 : 0;
      if (seg == 4) long_hold_req = 1'b1;
      tick_pct = $urandom_range(30, 60);
      high_pct = $urandom_range(30, 70);
      for (int n = 0; n < SEG_BEATS; n++) begin
        if ($urandom_range(99) < tick_pct)
          op = ($urandom_range(1) == 1) ? OP_TICK_ALT : OP_TICK;
        else
          op = ($urandom_range(99) < high_pct) ? OP_REQ_HIGH : OP_REQ_LOW;
        send_beat(make_beat(op, 16'($urandom_range(16'hFFFF)),
                            16'($urandom_range(16'hFFFF))), 1'b0, '0);
      end
    end

    // Empty both rings
    gap_pct   = 0;
    stall_pct = 0;
    while (ring_fill[HI] + ring_fill[LO] != 0)
      send_beat(make_beat(OP_TICK, 16'h0000, 16'($urandom_range(16'hFFFF))), 1'b0, '0);

    // Drain, wait out stray beats, then conclude
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES * 2) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
